/* sv/trs_pkg.sv */
// trs_pkg: shared types and constants of the trs transform matrix block
// item structs, q2.30 and q.32 angle constants, cordic arctangent table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

    localparam int DEF_FRAC_BITS     = 16;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam int IFRAC      = 30;
    localparam int MAX_STAGES = 24;

    localparam longint TWO_PI_Q32  = 64'sd26986075409;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] angle;
        logic               has_angle;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic               has_scale;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] col0_x;
        logic signed [31:0] col0_y;
        logic signed [31:0] col1_x;
        logic signed [31:0] col1_y;
        logic signed [31:0] col2_x;
        logic signed [31:0] col2_y;
    } t_out_item;

    // arctan(2^-i) in q2.30
    function automatic logic signed [31:0] atan_q30(input int i);
        logic signed [31:0] v;
        case (i)
            0:       v = 32'sd843314857;
            1:       v = 32'sd497837829;
            2:       v = 32'sd263043837;
            3:       v = 32'sd133525159;
            4:       v = 32'sd67021687;
            5:       v = 32'sd33543516;
            6:       v = 32'sd16775851;
            7:       v = 32'sd8388437;
            8:       v = 32'sd4194283;
            9:       v = 32'sd2097149;
            10:      v = 32'sd1048576;
            11:      v = 32'sd524288;
            12:      v = 32'sd262144;
            13:      v = 32'sd131072;
            14:      v = 32'sd65536;
            15:      v = 32'sd32768;
            16:      v = 32'sd16384;
            17:      v = 32'sd8192;
            18:      v = 32'sd4096;
            19:      v = 32'sd2048;
            20:      v = 32'sd1024;
            21:      v = 32'sd512;
            22:      v = 32'sd256;
            23:      v = 32'sd128;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/trs_transform_matrix.sv */
// trs_transform_matrix: 2d translate * scale * rotate matrix, one item per cycle unless stalled
// angle reduction, unrolled cordic, saturating q.FRAC_BITS products
// depends on trs_pkg
//
// usage:
//   input channel i_valid / o_stall carries one t_in_item (position, optional
//   angle, optional per-axis scale); output channel o_valid / i_stall carries
//   one t_out_item with the six varying matrix entries. an item moves on a
//   rising edge with valid high and stall low.
//   the pipeline has four stages of modulo 2*pi reduction by reciprocal
//   multiply, one quadrant fold stage, one stage per cordic iteration, then
//   trig select, multiply, round and saturate.
//   throughput is one item per cycle while no waiting result is stalled; every
//   stage is a register stage and the whole pipeline advances together.
//   when the receiver stalls with a result waiting, the pipeline freezes and
//   o_stall is raised; nothing is dropped or repeated, the waiting result holds.
//   reset is synchronous, active low, and clears all valid bits; the first
//   item can be taken in the cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module trs_transform_matrix
    import trs_pkg::*;
#(
    parameter int FRAC_BITS     = DEF_FRAC_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    localparam int N   = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    localparam int NS  = N + 8;
    localparam int SH  = IFRAC - FRAC_BITS;
    localparam int CW  = 34;
    localparam int ZW  = 35;
    localparam int MW  = 32 + CW;

    localparam longint TP     = (TWO_PI_Q32 + (longint'(1) << (31 - FRAC_BITS)))
                                >> (32 - FRAC_BITS);
    localparam int     TPW    = $clog2(TP + 1);
    localparam longint RECIP  = (longint'(1) << 32) / TP;
    localparam int     RW     = $clog2(RECIP + 1);
    localparam int     PW     = 32 + RW;
    localparam int     QTW    = RW + TPW;
    localparam longint K_OFS  = (longint'(1) << 31) % TP;
    localparam longint TP30   = TP << SH;

    localparam logic signed [ZW-1:0] C_PI      = ZW'(PI_Q30);
    localparam logic signed [ZW-1:0] C_HALF    = ZW'(HALF_PI_Q30);
    localparam logic signed [ZW-1:0] C_TP30    = ZW'(TP30);
    localparam logic signed [ZW-1:0] C_WRAP    = ZW'(TP30 - HALF_PI_Q30);
    localparam logic signed [ZW-1:0] C_WRAP_PI = ZW'(TP30 - PI_Q30);
    localparam logic signed [CW-1:0] C_GAIN    = CW'(GAIN_Q30);
    localparam logic signed [CW-1:0] C_ONE_T   = CW'(longint'(1) << IFRAC);
    localparam logic signed [31:0]   C_ONE_S   = 32'(longint'(1) << FRAC_BITS);
    localparam longint RND_HALF = longint'(1) << (IFRAC - 1);
    localparam longint SAT_MAX  = 64'sd2147483647;
    localparam longint SAT_MIN  = -64'sd2147483648;

    function automatic logic signed [31:0] round_sat(input logic signed [MW-1:0] p);
        logic signed [MW:0] t;
        logic signed [31:0] v;
        t = (MW+1)'(p) + (MW+1)'(RND_HALF);
        t = t >>> IFRAC;
        if (t > (MW+1)'(SAT_MAX)) begin
            v = 32'(SAT_MAX);
        end else if (t < (MW+1)'(SAT_MIN)) begin
            v = 32'(SAT_MIN);
        end else begin
            v = 32'(t);
        end
        return v;
    endfunction

    logic            en;
    logic [NS-1:0]   r_vld;
    t_in_item        r_itm [0:NS-2];

    logic [PW-1:0]   r_prod;
    logic [32:0]     r_qt;
    logic [TPW-1:0]  r_rem;
    logic [TPW-1:0]  r_red;

    logic signed [CW-1:0] r_x [0:N];
    logic signed [CW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic [N:0]           r_flip;

    logic signed [31:0]   r_sx, r_sy;
    logic signed [CW-1:0] r_c, r_s, r_sn;
    logic signed [MW-1:0] r_p0, r_p1, r_p2, r_p3;
    t_out_item            r_out;

    logic [31:0]          n_u;
    logic [RW-1:0]        n_q;
    logic [QTW-1:0]       n_qt;
    logic [32:0]          n_diff, n_rem;
    logic signed [ZW-1:0] n_zr, n_z;
    logic                 n_flip;
    logic signed [CW-1:0] n_cf, n_sf;
    logic signed [MW-1:0] n_p0, n_p1, n_p2, n_p3;

    assign o_stall = r_vld[NS-1] & i_stall;
    assign en      = ~o_stall;
    assign o_valid = r_vld[NS-1];
    assign o_item  = r_out;

    // angle offset by 2^31 so the remainder works on an unsigned value
    assign n_u  = {~i_item.angle[31], i_item.angle[30:0]};
    assign n_q  = r_prod[PW-1:32];
    assign n_qt = QTW'(n_q) * QTW'(TP);

    always_comb begin
        n_diff = {1'b0, {r_itm[1].angle[31] ^ 1'b1, r_itm[1].angle[30:0]}} - r_qt;
        n_rem  = (n_diff >= 33'(TP)) ? n_diff - 33'(TP) : n_diff;
    end

    // quadrant fold to [-pi/2, pi/2]
    always_comb begin
        n_zr = ZW'(r_red) << SH;
        if (n_zr <= C_HALF) begin
            n_z    = n_zr;
            n_flip = 1'b0;
        end else if (n_zr <= C_PI) begin
            n_z    = n_zr - C_PI;
            n_flip = 1'b1;
        end else if (n_zr < C_WRAP) begin
            n_z    = n_zr - C_WRAP_PI;
            n_flip = 1'b1;
        end else begin
            n_z    = n_zr - C_TP30;
            n_flip = 1'b0;
        end
    end

    always_comb begin
        n_cf = r_flip[N] ? -r_x[N] : r_x[N];
        n_sf = r_flip[N] ? -r_y[N] : r_y[N];
    end

    always_comb begin
        n_p0 = r_sx * r_c;
        n_p1 = r_sy * r_s;
        n_p2 = r_sx * r_sn;
        n_p3 = r_sy * r_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_itm[0] <= i_item;
            for (int k = 1; k <= NS - 2; k++) begin
                r_itm[k] <= r_itm[k-1];
            end
            r_prod <= PW'(n_u) * PW'(RECIP);
            r_qt   <= 33'(n_qt);
            r_rem  <= TPW'(n_rem);
            r_red  <= (r_rem >= TPW'(K_OFS)) ? r_rem - TPW'(K_OFS)
                                             : r_rem + TPW'(TP - K_OFS);
            r_z[0]    <= n_z;
            r_x[0]    <= C_GAIN;
            r_y[0]    <= '0;
            r_flip[0] <= n_flip;

            // one cordic iteration per register stage
            for (int i = 0; i < N; i++) begin
                r_flip[i+1] <= r_flip[i];
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ZW'(atan_q30(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ZW'(atan_q30(i));
                end
            end

            r_sx <= r_itm[4+N].has_scale ? r_itm[4+N].scale_x : C_ONE_S;
            r_sy <= r_itm[4+N].has_scale ? r_itm[4+N].scale_y : C_ONE_S;
            r_c  <= r_itm[4+N].has_angle ? n_cf : C_ONE_T;
            r_s  <= r_itm[4+N].has_angle ? n_sf : '0;
            r_sn <= r_itm[4+N].has_angle ? -n_sf : '0;

            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;

            r_out.col0_x <= round_sat(r_p0);
            r_out.col0_y <= round_sat(r_p1);
            r_out.col1_x <= round_sat(r_p2);
            r_out.col1_y <= round_sat(r_p3);
            r_out.col2_x <= r_itm[NS-2].pos_x;
            r_out.col2_y <= r_itm[NS-2].pos_y;
        end
    end

endmodule

`default_nettype wire

/* sv/trs_checker.sv */
// trs_checker: port-level checks of trs_transform_matrix
// bound to the top level, sees its ports only
// depends on trs_pkg
`timescale 1ns / 1ps
`default_nettype none

module trs_checker
    import trs_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_stall,
    input wire t_in_item  i_item,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_item o_item
);

    // stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_item))
        else $error("result changed while stalled");

    // input side only backs up when a result is waiting on a stalled receiver
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

endmodule

bind trs_transform_matrix trs_checker u_trs_checker (.*);

`default_nettype wire
